// ===== src/ordered_key_value_table_assert.svh =====
// assertion macros used by the table's checker
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication
`define OKVT_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("okvt check failed");

// next-cycle implication
`define OKVT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("okvt check failed");

`endif

// ===== src/okvt_pkg.sv =====
// types and codes of the ordered key/value table
package okvt_pkg;

   localparam logic [2:0] OP_INSERT           = 3'd0;
   localparam logic [2:0] OP_UPDATE           = 3'd1;
   localparam logic [2:0] OP_INSERT_OR_UPDATE = 3'd2;
   localparam logic [2:0] OP_ERASE            = 3'd3;
   localparam logic [2:0] OP_LOOKUP           = 3'd4;
   localparam logic [2:0] OP_ADD_OR_INSERT    = 3'd5;
   localparam logic [2:0] OP_CLEAR            = 3'd6;
   localparam logic [2:0] OP_NOP              = 3'd7;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_PRESENT   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] req_key;
      logic signed [31:0] req_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               was_found;
      logic signed [31:0] read_value;
      logic [4:0]         entry_count;
   } rsp_type;

endpackage

// ===== src/okvt_entry_ram.sv =====
// entry memory: one write port, one read port with registered read data
module okvt_entry_ram #(
   parameter int DEPTH     = 16,
   parameter int WIDTH     = 64,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ordered_key_value_table.sv =====
// ordered key/value table: scan, modify and shift over one entry memory
//
// channel   ports                          handshake
// request   start, busy, req_payload       taken when start && !busy
// response  rsp_valid, rsp_payload         one-cycle strobe, no backpressure
//
// clear, no-op and any request on an empty table answer in the cycle after start.
// other requests scan the entry memory one entry per cycle, from entry 0 up to the
// match, or over every stored entry on a miss. erase answers at the match, then
// stays busy moving later entries down, one write per cycle on the memory, with a
// read of the next entry alongside each write but the last.
// reset empties the table at once; the response side never stalls.
module ordered_key_value_table
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int WIDE_BITS  = CNT_BITS + 1;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_we, ram_re;
   logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
   logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

   logic [2:0]            cur_op;
   logic [KEY_BITS-1:0]   cur_key, req_key_bits;
   logic [VALUE_BITS-1:0] cur_val, req_val_bits;
   logic [KEY_BITS-1:0]   stored_key;
   logic [VALUE_BITS-1:0] stored_val, sum_val;
   logic [WIDE_BITS-1:0]  idx_wide, count_wide;
   logic [63:0]           key_ext, val_ext;
   logic                  hit, miss;

   function automatic logic signed [31:0] value_out(input logic [VALUE_BITS-1:0] v);
      logic [63:0] w;
      w = 64'($signed(v));
      return w[31:0];
   endfunction

   function automatic logic [4:0] count_out(input logic [CNT_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return w[4:0];
   endfunction

   okvt_entry_ram #(
      .DEPTH     (CAPACITY),
      .WIDTH     (ENTRY_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign key_ext      = 64'(req_payload.req_key);
   assign val_ext      = 64'(req_payload.req_value);
   assign req_key_bits = key_ext[KEY_BITS-1:0];
   assign req_val_bits = val_ext[VALUE_BITS-1:0];

   assign cur_op  = (state_ff == S_IDLE) ? req_payload.opcode : op_ff;
   assign cur_key = (state_ff == S_IDLE) ? req_key_bits : key_ff;
   assign cur_val = (state_ff == S_IDLE) ? req_val_bits : val_ff;

   assign stored_key = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
   assign stored_val = ram_rdata[VALUE_BITS-1:0];
   assign sum_val    = stored_val + val_ff;
   assign idx_wide   = WIDE_BITS'(idx_ff);
   assign count_wide = WIDE_BITS'(count_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      hit          = 1'b0;
      miss         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_payload.opcode;
               key_in = req_key_bits;
               val_in = req_val_bits;
               if (req_payload.opcode == OP_CLEAR) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{ST_DONE, 1'b0, 32'sd0, 5'd0};
               end else if (req_payload.opcode == OP_NOP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{ST_DONE, 1'b0, 32'sd0, 5'd0};
               end else if (count_ff == '0) begin
                  miss = 1'b1;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  idx_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stored_key == key_ff) begin
               hit      = 1'b1;
               state_in = S_IDLE;
            end else if (idx_wide + WIDE_BITS'(1) == count_wide) begin
               miss     = 1'b1;
               state_in = S_IDLE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff + IDX_BITS'(1);
               idx_in    = idx_ff + IDX_BITS'(1);
            end
         end
         S_SHIFT: begin
            // rd data holds the entry one above idx
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (idx_wide + WIDE_BITS'(1) < count_wide) begin
               ram_re    = 1'b1;
               ram_raddr = IDX_BITS'(idx_wide + WIDE_BITS'(2));
               idx_in    = idx_ff + IDX_BITS'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (miss) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{ST_NOT_FOUND, 1'b0, 32'sd0, 5'd0};
         unique case (cur_op)
            OP_INSERT, OP_INSERT_OR_UPDATE, OP_ADD_OR_INSERT: begin
               if (WIDE_BITS'(count_ff) >= WIDE_BITS'(CAPACITY)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ram_we            = 1'b1;
                  ram_waddr         = IDX_BITS'(count_ff);
                  ram_wdata         = {cur_key, cur_val};
                  count_in          = count_ff + CNT_BITS'(1);
                  rsp_in.status     = ST_DONE;
                  rsp_in.read_value = value_out(cur_val);
               end
            end
            default: begin
               rsp_in.status = ST_NOT_FOUND;
            end
         endcase
      end

      if (hit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{ST_DONE, 1'b1, 32'sd0, 5'd0};
         unique case (op_ff)
            OP_INSERT: begin
               rsp_in.status     = ST_PRESENT;
               rsp_in.read_value = value_out(stored_val);
            end
            OP_UPDATE, OP_INSERT_OR_UPDATE: begin
               ram_we            = 1'b1;
               ram_waddr         = idx_ff;
               ram_wdata         = {key_ff, val_ff};
               rsp_in.read_value = value_out(val_ff);
            end
            OP_ADD_OR_INSERT: begin
               ram_we            = 1'b1;
               ram_waddr         = idx_ff;
               ram_wdata         = {key_ff, sum_val};
               rsp_in.read_value = value_out(sum_val);
            end
            OP_ERASE: begin
               count_in = count_ff - CNT_BITS'(1);
               // later entries move down one place
               if (idx_wide + WIDE_BITS'(1) < count_wide) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + IDX_BITS'(1);
                  state_in  = S_SHIFT;
               end
            end
            OP_LOOKUP: begin
               rsp_in.read_value = value_out(stored_val);
            end
            default: begin
               rsp_in.was_found = 1'b0;
            end
         endcase
      end

      rsp_in.entry_count = count_out(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/okvt_checker.sv =====
// port-level checks of the ordered key/value table, bound to the top level
`include "ordered_key_value_table_assert.svh"

module okvt_checker
   import okvt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   // an accepted request either answers next cycle or keeps the block busy
   `OKVT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)

   `OKVT_ASSERT_NOW(a_full_clean, clock, reset, rsp_valid && rsp_payload.status == ST_FULL, !rsp_payload.was_found && rsp_payload.read_value == 32'sd0)

   `OKVT_ASSERT_NOW(a_miss_clean, clock, reset, rsp_valid && rsp_payload.status == ST_NOT_FOUND, !rsp_payload.was_found && rsp_payload.read_value == 32'sd0)

   `OKVT_ASSERT_NOW(a_present_found, clock, reset, rsp_valid && rsp_payload.status == ST_PRESENT, rsp_payload.was_found)

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

// ===== tb/ordered_key_value_table_tb.sv =====
// self-checking testbench of the ordered key/value table, with a predicting scoreboard
module ordered_key_value_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import okvt_pkg::*;

   localparam int CAPACITY         = 16;
   localparam int KEY_POOL_SIZE    = 20;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 40;

   class response_scoreboard;
      logic [31:0] stored_keys   [CAPACITY];
      logic [31:0] stored_values [CAPACITY];
      int          used_entries = 0;
      rsp_type     pending_responses [$];
      int          error_count = 0;

      function int locate_key(logic [31:0] key);
         for (int i = 0; i < used_entries; i++) begin
            if (stored_keys[i] == key) return i;
         end
         return -1;
      endfunction

      // updates the table copy and gives the response the request must produce
      function rsp_type apply_request(req_type r);
         int          slot;
         rsp_type     res;
         logic [31:0] key;
         logic [31:0] val;
         key = r.req_key;
         val = r.req_value;
         slot = locate_key(key);
         res = '0;
         res.was_found = (slot >= 0);
         case (r.opcode)
            OP_INSERT, OP_INSERT_OR_UPDATE, OP_ADD_OR_INSERT: begin
               if (slot >= 0) begin
                  if (r.opcode == OP_INSERT) res.status = ST_PRESENT;
                  else if (r.opcode == OP_INSERT_OR_UPDATE) stored_values[slot] = val;
                  else stored_values[slot] = stored_values[slot] + val;
                  res.read_value = stored_values[slot];
               end else if (used_entries >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  stored_keys[used_entries]   = key;
                  stored_values[used_entries] = val;
                  used_entries++;
                  res.read_value = val;
               end
            end
            OP_UPDATE: begin
               if (slot >= 0) begin
                  stored_values[slot] = val;
                  res.read_value = val;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
            end
            OP_ERASE: begin
               if (slot >= 0) begin
                  // later entries move down to close the gap
                  for (int i = slot; i + 1 < used_entries; i++) begin
                     stored_keys[i]   = stored_keys[i + 1];
                     stored_values[i] = stored_values[i + 1];
                  end
                  used_entries--;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
            end
            OP_LOOKUP: begin
               if (slot >= 0) res.read_value = stored_values[slot];
               else res.status = ST_NOT_FOUND;
            end
            OP_CLEAR: begin
               used_entries = 0;
               res.was_found = 1'b0;
            end
            default: res.was_found = 1'b0;
         endcase
         res.entry_count = used_entries[4:0];
         return res;
      endfunction

      function void note_request(req_type r);
         pending_responses.push_back(apply_request(r));
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_responses.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.was_found !== want.was_found)
            report($sformatf("was_found got %0d want %0d", got.was_found, want.was_found));
         if (got.read_value !== want.read_value)
            report($sformatf("read_value got %h want %h", got.read_value, want.read_value));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d", got.entry_count,
                             want.entry_count));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   response_scoreboard board = new;
   logic [31:0]        key_pool [KEY_POOL_SIZE];
   int                 quiet_cycles = 0;

   ordered_key_value_table DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // responses are checked before the request taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_payload);
         if (start && !busy) board.note_request(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic req_type make_req(logic [2:0] op, logic [31:0] key, logic [31:0] val);
      req_type r;
      r.opcode    = op;
      r.req_key   = key;
      r.req_value = val;
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // mostly keys from a small pool so hits and a full table are common
   function automatic req_type random_request();
      int          roll;
      logic [2:0]  op;
      logic [31:0] key;
      roll = $urandom_range(99);
      if (roll < 20) op = OP_INSERT;
      else if (roll < 32) op = OP_UPDATE;
      else if (roll < 47) op = OP_INSERT_OR_UPDATE;
      else if (roll < 62) op = OP_ERASE;
      else if (roll < 80) op = OP_LOOKUP;
      else if (roll < 95) op = OP_ADD_OR_INSERT;
      else if (roll < 97) op = OP_CLEAR;
      else op = OP_NOP;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      else key = $urandom;
      return make_req(op, key, random_word());
   endfunction

   task automatic send_request(req_type r);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_with_gaps(req_type r, int idle_pct);
      if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 4));
      send_request(r);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_responses.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          idle_pcts [3];
      logic [31:0] fill_keys [CAPACITY];
      logic [31:0] fill_values [CAPACITY];
      logic [2:0]  fill_op;
      idle_pcts   = '{0, 45, 11};
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
      fill_keys[0] = 32'h8000_0000; fill_values[0] = 32'h7fff_ffff;
      fill_keys[1] = 32'h7fff_ffff; fill_values[1] = 32'h8000_0000;
      fill_keys[2] = 32'h0000_0000; fill_values[2] = 32'hffff_ffff;
      fill_keys[3] = 32'hffff_ffff; fill_values[3] = 32'h0000_0000;
      for (int i = 4; i < CAPACITY; i++) begin
         fill_keys[i]   = 32'h0000_1000 + i;
         fill_values[i] = $urandom;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, fill with extremes, full table, wrap, shifts
      send_request(make_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000));
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == CAPACITY - 2) fill_op = OP_INSERT_OR_UPDATE;
         else if (i == CAPACITY - 1) fill_op = OP_ADD_OR_INSERT;
         else fill_op = OP_INSERT;
         send_request(make_req(fill_op, fill_keys[i], fill_values[i]));
      end
      send_request(make_req(OP_INSERT, fill_keys[0], 32'h1234_5678));
      send_request(make_req(OP_INSERT, 32'h5555_aaaa, 32'h0000_0001));
      send_request(make_req(OP_INSERT_OR_UPDATE, 32'h5555_aaaa, 32'h0000_0002));
      send_request(make_req(OP_ADD_OR_INSERT, 32'h5555_aaaa, 32'h0000_0003));
      send_request(make_req(OP_ADD_OR_INSERT, fill_keys[0], 32'h0000_0001));
      send_request(make_req(OP_UPDATE, fill_keys[1], 32'hffff_ffff));
      send_request(make_req(OP_INSERT_OR_UPDATE, fill_keys[2], 32'h1234_5678));
      send_request(make_req(OP_ERASE, fill_keys[0], 32'h0000_0000));
      send_request(make_req(OP_LOOKUP, fill_keys[CAPACITY - 1], 32'h0000_0000));
      send_request(make_req(OP_ERASE, fill_keys[CAPACITY - 1], 32'h0000_0000));
      send_request(make_req(OP_UPDATE, fill_keys[0], 32'h0000_0007));
      send_request(make_req(OP_ERASE, fill_keys[0], 32'h0000_0000));
      send_request(make_req(OP_NOP, fill_keys[1], 32'hffff_ffff));
      send_request(make_req(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff));
      send_request(make_req(OP_ERASE, fill_keys[1], 32'h0000_0000));
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_with_gaps(random_request(), idle_pcts[phase]);
            // now and then let the table go quiet before the next request
            if ($urandom_range(39) == 0) wait_for_drain();
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/okvt_pkg.sv
src/okvt_entry_ram.sv
src/ordered_key_value_table.sv
src/okvt_checker.sv
tb/ordered_key_value_table_tb.sv
